### design/asw_pkg.sv
// ----------------------------------------------------------------------------
// asw_pkg
// shared types, widths and reset values of the adaptive score weight block
// ----------------------------------------------------------------------------
package asw_pkg;

  localparam int MAX_WINDOW_DEF = 64;

  localparam int SCORE_W = 16;
  localparam int WLEN_W  = 7;
  localparam int CFG_W   = 16;
  localparam int REGIDX_W = 3;

  // raw weight is floor(base * factor / 2^12), at most 37 bits
  localparam int RAW_W = 37;
  localparam int TOT_W = RAW_W + 2;
  localparam int DVD_W = TOT_W + 17;
  localparam int QUO_W = 17;

  localparam logic [15:0] BASE_SCENE_RST  = 16'd29491;
  localparam logic [15:0] BASE_MOTION_RST = 16'd13107;
  localparam logic [15:0] BASE_TEXT_RST   = 16'd22938;
  localparam logic [15:0] MIN_W_RST       = 16'd0;
  localparam logic [15:0] MAX_W_RST       = 16'd65535;
  localparam logic [6:0]  WLEN_RST        = 7'd30;
  localparam logic [15:0] ALPHA_RST       = 16'd32768;
  localparam logic [15:0] BETA_RST        = 16'd4096;

  typedef enum logic [REGIDX_W-1:0] {
    REG_BASE_SCENE  = 3'd0,
    REG_BASE_MOTION = 3'd1,
    REG_BASE_TEXT   = 3'd2,
    REG_MIN_WEIGHT  = 3'd3,
    REG_MAX_WEIGHT  = 3'd4,
    REG_WIN_LEN     = 3'd5,
    REG_ALPHA       = 3'd6,
    REG_BETA        = 3'd7
  } asw_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_UPDATE,
    OP_AVG_GO,
    OP_AVG_END,
    OP_MUL_A,
    OP_MUL_B,
    OP_ACT,
    OP_FACTOR,
    OP_RAW,
    OP_W_GO,
    OP_W_END,
    OP_PUBLISH
  } asw_op_t;

  typedef struct packed {
    asw_op_t     op;
    logic [1:0]  ch;
  } asw_cmd_t;

  typedef struct packed {
    logic div_done;
    logic total_zero;
    logic out_free;
  } asw_stat_t;

endpackage

### design/asw_if.sv
// ----------------------------------------------------------------------------
// asw input and result channels
// valid/ready channels carrying the score item and the weight result
// ----------------------------------------------------------------------------
interface asw_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] scene_score;
  logic [15:0] motion_score;
  logic [15:0] text_score;

  modport source (output valid, scene_score, motion_score, text_score, input ready);
  modport sink   (input valid, scene_score, motion_score, text_score, output ready);
endinterface

interface asw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] weight_scene_out;
  logic [15:0] weight_motion_out;
  logic [15:0] weight_text_out;
  logic [15:0] avg_scene;
  logic [15:0] avg_motion;
  logic [15:0] avg_text;
  logic        fallback_used;

  modport source (output valid, weight_scene_out, weight_motion_out, weight_text_out,
                  avg_scene, avg_motion, avg_text, fallback_used, input ready);
  modport sink   (input valid, weight_scene_out, weight_motion_out, weight_text_out,
                  avg_scene, avg_motion, avg_text, fallback_used, output ready);
endinterface

### design/asw_ram.sv
// ----------------------------------------------------------------------------
// asw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module asw_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end
endmodule

### design/asw_div.sv
// ----------------------------------------------------------------------------
// asw_div
// restoring divider, one quotient bit per cycle, quotient known to fit QUO_W
// ----------------------------------------------------------------------------
module asw_div #(
  parameter int DVD_W = 56,
  parameter int DVS_W = 39,
  parameter int Q_W   = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done_r,
  output logic [Q_W-1:0]   q_r
);
  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, q_r[Q_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DVS_W'(dividend >> Q_W);
      q_r   <= dividend[Q_W-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[Q_W-2:0], ge};
    end
  end
endmodule

### design/asw_dp.sv
// ----------------------------------------------------------------------------
// asw_dp
// window store, running sums, multiply chain, divider and result register
// ----------------------------------------------------------------------------
module asw_dp #(
  parameter int MAX_WINDOW = asw_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  asw_pkg::asw_cmd_t             cmd,
  output asw_pkg::asw_stat_t            stat,
  input  logic                          cfg_we,
  input  logic [asw_pkg::REGIDX_W-1:0]  cfg_index,
  input  logic [asw_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [15:0]                   in_scene,
  input  logic [15:0]                   in_motion,
  input  logic [15:0]                   in_text,
  input  logic                          out_ready,
  output logic                          out_valid_r,
  output logic [15:0]                   out_w_r [3],
  output logic [15:0]                   out_avg_r [3],
  output logic                          out_fb_r
);
  import asw_pkg::*;

  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SCORE_W + CNT_W;
  localparam int CMP_W  = ((CNT_W > WLEN_W) ? CNT_W : WLEN_W) + 1;
  localparam int IX_W   = CNT_W + 1;

  // configuration
  logic [15:0] base_r [3];
  logic [15:0] min_r, max_r, alpha_r, beta_r;
  logic [6:0]  wlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r[0] <= BASE_SCENE_RST;
      base_r[1] <= BASE_MOTION_RST;
      base_r[2] <= BASE_TEXT_RST;
      min_r     <= MIN_W_RST;
      max_r     <= MAX_W_RST;
      wlen_r    <= WLEN_RST;
      alpha_r   <= ALPHA_RST;
      beta_r    <= BETA_RST;
    end else if (cfg_we) begin
      unique case (asw_reg_t'(cfg_index))
        REG_BASE_SCENE:  base_r[0] <= cfg_wdata;
        REG_BASE_MOTION: base_r[1] <= cfg_wdata;
        REG_BASE_TEXT:   base_r[2] <= cfg_wdata;
        REG_MIN_WEIGHT:  min_r     <= cfg_wdata;
        REG_MAX_WEIGHT:  max_r     <= cfg_wdata;
        REG_WIN_LEN:     wlen_r    <= cfg_wdata[WLEN_W-1:0];
        REG_ALPHA:       alpha_r   <= cfg_wdata;
        REG_BETA:        beta_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // window bookkeeping
  logic [SUM_W-1:0]  sum_r [3];
  logic [CNT_W-1:0]  fill_r;
  logic [SLOT_W-1:0] wslot_r;
  logic              retire_r;
  logic [15:0]       score_r [3];
  logic [CMP_W-1:0]  len;
  logic [IX_W-1:0]   old_ix;
  logic [SLOT_W-1:0] old_slot;
  logic [47:0]       old_data;
  logic              retire_now;

  always_comb begin
    if (wlen_r == '0) begin
      len = CMP_W'(1);
    end else if (CMP_W'(wlen_r) > CMP_W'(MAX_WINDOW)) begin
      len = CMP_W'(MAX_WINDOW);
    end else begin
      len = CMP_W'(wlen_r);
    end
    retire_now = (CMP_W'(fill_r) + CMP_W'(1)) > len;
    old_ix = IX_W'(wslot_r) + IX_W'(MAX_WINDOW) - IX_W'(fill_r);
    if (old_ix >= IX_W'(MAX_WINDOW)) begin
      old_ix = old_ix - IX_W'(MAX_WINDOW);
    end
    old_slot = old_ix[SLOT_W-1:0];
  end

  asw_ram #(.WIDTH(3 * SCORE_W), .DEPTH(MAX_WINDOW)) u_win (
    .clk     (clk),
    .we      (cmd.op == OP_UPDATE),
    .waddr   (wslot_r),
    .wdata   ({score_r[0], score_r[1], score_r[2]}),
    .re      (cmd.op == OP_LOAD),
    .raddr   (old_slot),
    .rdata_r (old_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      wslot_r <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
      end
    end else if (cmd.op == OP_UPDATE) begin
      if (!retire_r) begin
        fill_r <= fill_r + 1'b1;
      end
      wslot_r <= (wslot_r == SLOT_W'(MAX_WINDOW - 1)) ? '0 : wslot_r + 1'b1;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= sum_r[i] + SUM_W'(score_r[i])
                    - (retire_r ? SUM_W'(old_data[47 - 16*i -: 16]) : '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      score_r[0] <= in_scene;
      score_r[1] <= in_motion;
      score_r[2] <= in_text;
      retire_r   <= retire_now;
    end
  end

  // divider shared by averages and normalization
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [TOT_W-1:0] div_dvs;
  logic             div_done;
  logic [QUO_W-1:0] div_q;

  logic [15:0]      avg_r [3];
  logic [31:0]      mula_r;
  logic [32:0]      acc_r;
  logic [15:0]      act_r;
  logic [32:0]      factor_r;
  logic [RAW_W-1:0] raw_r [3];
  logic [TOT_W-1:0] total_r;
  logic [15:0]      w_r [3];
  logic [48:0]      raw_prod;
  logic [15:0]      w_clamp;

  always_comb begin
    div_start = (cmd.op == OP_AVG_GO) || (cmd.op == OP_W_GO);
    if (cmd.op == OP_AVG_GO) begin
      div_dvd = DVD_W'(sum_r[cmd.ch]) + DVD_W'(fill_r >> 1);
      div_dvs = TOT_W'(fill_r);
    end else begin
      div_dvd = (DVD_W'(raw_r[cmd.ch]) << 16) + DVD_W'(total_r >> 1);
      div_dvs = total_r;
    end
    raw_prod = 49'(base_r[cmd.ch]) * 49'(factor_r);
    if (div_q < {1'b0, min_r}) begin
      w_clamp = min_r;
    end else if (div_q > {1'b0, max_r}) begin
      w_clamp = max_r;
    end else begin
      w_clamp = div_q[15:0];
    end
  end

  asw_div #(.DVD_W(DVD_W), .DVS_W(TOT_W), .Q_W(QUO_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done_r   (div_done),
    .q_r      (div_q)
  );

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD:    total_r <= '0;
      OP_AVG_END: avg_r[cmd.ch] <= div_q[15:0];
      OP_MUL_A:   mula_r <= 32'(alpha_r) * 32'(score_r[cmd.ch]);
      OP_MUL_B:   acc_r <= 33'(mula_r)
                           + 33'(17'h10000 - {1'b0, alpha_r}) * 33'(avg_r[cmd.ch]);
      OP_ACT:     act_r <= 16'((acc_r + 33'd32768) >> 16);
      OP_FACTOR:  factor_r <= (33'd1 << 28) + 33'(beta_r) * 33'(act_r);
      OP_RAW: begin
        raw_r[cmd.ch] <= RAW_W'(raw_prod >> 12);
        total_r       <= total_r + TOT_W'(raw_prod >> 12);
      end
      OP_W_END:   w_r[cmd.ch] <= w_clamp;
      default: ;
    endcase
  end

  // result register
  logic publish;
  assign publish = (cmd.op == OP_PUBLISH) && stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      out_fb_r <= (total_r == '0);
      for (int i = 0; i < 3; i++) begin
        out_w_r[i]   <= (total_r == '0) ? base_r[i] : w_r[i];
        out_avg_r[i] <= avg_r[i];
      end
    end
  end

  always_comb begin
    stat.div_done   = div_done;
    stat.total_zero = (total_r == '0);
    stat.out_free   = !out_valid_r || out_ready;
  end
endmodule

### design/asw_ctrl.sv
// ----------------------------------------------------------------------------
// asw_ctrl
// sequencer stepping the datapath through window update, channels and division
// ----------------------------------------------------------------------------
module asw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  asw_pkg::asw_stat_t stat,
  output asw_pkg::asw_cmd_t  cmd
);
  import asw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UPDATE, S_AVG_GO, S_AVG_WAIT, S_MUL_A, S_MUL_B, S_ACT,
    S_FACTOR, S_RAW, S_CHECK, S_W_GO, S_W_WAIT, S_PUBLISH
  } state_t;

  state_t     state_r;
  logic [1:0] ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE:     if (in_valid) state_r <= S_UPDATE;
        S_UPDATE: begin
          ch_r    <= '0;
          state_r <= S_AVG_GO;
        end
        S_AVG_GO:   state_r <= S_AVG_WAIT;
        S_AVG_WAIT: if (stat.div_done) state_r <= S_MUL_A;
        S_MUL_A:    state_r <= S_MUL_B;
        S_MUL_B:    state_r <= S_ACT;
        S_ACT:      state_r <= S_FACTOR;
        S_FACTOR:   state_r <= S_RAW;
        S_RAW: begin
          if (ch_r == 2'd2) begin
            state_r <= S_CHECK;
          end else begin
            ch_r    <= ch_r + 1'b1;
            state_r <= S_AVG_GO;
          end
        end
        S_CHECK: begin
          ch_r    <= '0;
          state_r <= stat.total_zero ? S_PUBLISH : S_W_GO;
        end
        S_W_GO:     state_r <= S_W_WAIT;
        S_W_WAIT: begin
          if (stat.div_done) begin
            if (ch_r == 2'd2) begin
              state_r <= S_PUBLISH;
            end else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= S_W_GO;
            end
          end
        end
        S_PUBLISH:  if (stat.out_free) state_r <= S_IDLE;
        default:    state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready = (state_r == S_IDLE);
    cmd.ch   = ch_r;
    unique case (state_r)
      S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_UPDATE:   cmd.op = OP_UPDATE;
      S_AVG_GO:   cmd.op = OP_AVG_GO;
      S_AVG_WAIT: cmd.op = stat.div_done ? OP_AVG_END : OP_NONE;
      S_MUL_A:    cmd.op = OP_MUL_A;
      S_MUL_B:    cmd.op = OP_MUL_B;
      S_ACT:      cmd.op = OP_ACT;
      S_FACTOR:   cmd.op = OP_FACTOR;
      S_RAW:      cmd.op = OP_RAW;
      S_W_GO:     cmd.op = OP_W_GO;
      S_W_WAIT:   cmd.op = stat.div_done ? OP_W_END : OP_NONE;
      S_PUBLISH:  cmd.op = OP_PUBLISH;
      default:    cmd.op = OP_NONE;
    endcase
  end
endmodule

### design/adaptive_score_weight_calculator_unit.sv
// ----------------------------------------------------------------------------
// adaptive_score_weight_calculator_unit
// windowed score averages and normalized, clamped channel weights
// ----------------------------------------------------------------------------
// sequence: per item the shared divider runs six times (three averages,
//   three normalizations), or only the three averages when all base weights
//   are zero; each division is a start followed by waiting for its done
// flow: one item at a time; the sequencer waits at publish while a stalled
//   result holds the output register; the next item is taken while a finished
//   result still waits in the output register
// reset: synchronous active-low; configuration to its defaults, window empty,
//   window store contents left as they are (only written entries are used)
module adaptive_score_weight_calculator_unit #(
  parameter int MAX_WINDOW = asw_pkg::MAX_WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  asw_in_if.sink                       in_chan,
  asw_out_if.source                    out_chan,
  input  logic                         cfg_we,
  input  logic [asw_pkg::REGIDX_W-1:0] cfg_index,
  input  logic [asw_pkg::CFG_W-1:0]    cfg_wdata
);
  import asw_pkg::*;

  // command and status between sequencer and datapath
  asw_cmd_t  cmd;
  asw_stat_t stat;

  logic [15:0] w_r   [3];
  logic [15:0] avg_r [3];
  logic        fb_r;
  logic        ovalid_r;

  // sequencer: one item at a time, channels handled in turn
  asw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: window ram, sums, multiplier chain, divider, result register
  asw_dp #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_scene    (in_chan.scene_score),
    .in_motion   (in_chan.motion_score),
    .in_text     (in_chan.text_score),
    .out_ready   (out_chan.ready),
    .out_valid_r (ovalid_r),
    .out_w_r     (w_r),
    .out_avg_r   (avg_r),
    .out_fb_r    (fb_r)
  );

  // result transfer
  assign out_chan.valid             = ovalid_r;
  assign out_chan.weight_scene_out  = w_r[0];
  assign out_chan.weight_motion_out = w_r[1];
  assign out_chan.weight_text_out   = w_r[2];
  assign out_chan.avg_scene         = avg_r[0];
  assign out_chan.avg_motion        = avg_r[1];
  assign out_chan.avg_text          = avg_r[2];
  assign out_chan.fallback_used     = fb_r;
endmodule
